// ----- sv/tape_pulse_symbol_encoder_defines.svh -----
// Assertion macros shared by the tape pulse symbol encoder.
`ifndef TAPE_PULSE_SYMBOL_ENCODER_DEFINES_SVH
`define TAPE_PULSE_SYMBOL_ENCODER_DEFINES_SVH

// Antecedent implies consequent in the same cycle, ignored during reset.
`define TPSE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tape pulse symbol encoder: same-cycle check failed");

// Antecedent implies consequent in the following cycle, ignored during reset.
`define TPSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tape pulse symbol encoder: next-cycle check failed");

`endif

// ----- sv/tpse_pkg.sv -----
// Types and constants shared by the tape pulse symbol encoder modules.
package tpse_pkg;

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int US_W    = 10;
  localparam int STEP_W  = 4;
  localparam int CFG_IDX_W = 3;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_LEADER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PLAIN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DATA   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END    = 2'd3;

  // Symbol kinds on the result channel.
  localparam logic [KIND_W-1:0] KIND_ZERO = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ONE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SYNC = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NEW  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP    = 3'd4;

  // Configuration reset values.
  localparam logic [US_W-1:0] RST_SHORT  = 10'd176;
  localparam logic [US_W-1:0] RST_MEDIUM = 10'd256;
  localparam logic [US_W-1:0] RST_LONG   = 10'd336;
  localparam logic [US_W-1:0] RST_LEADER = 10'd750;
  localparam logic [US_W-1:0] RST_GAP    = 10'd30;

  // Sequencer steps of one job.
  localparam logic [STEP_W-1:0] STEP_NEW    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_PARITY = 4'd9;
  localparam logic [STEP_W-1:0] STEP_MARK   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_GAP    = 4'd11;

  // A unit repeat count.
  localparam logic [US_W-1:0] REPEAT_ONE = 10'd1;

  // One classified job between front and back.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
  } job_t;

  // The configuration register set.
  typedef struct packed {
    logic [US_W-1:0] short_half_us;
    logic [US_W-1:0] medium_half_us;
    logic [US_W-1:0] long_half_us;
    logic [US_W-1:0] leader_sync_symbols;
    logic [US_W-1:0] gap_sync_symbols;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0] symbol_kind;
    logic [US_W-1:0]   first_half_us;
    logic [US_W-1:0]   second_half_us;
    logic [US_W-1:0]   repeat_count;
    logic              last;
  } result_t;

endpackage

// ----- sv/tpse_job_q.sv -----
// Two-entry job queue between the front and back of the encoder.
module tpse_job_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  tpse_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output tpse_pkg::job_t rd_job
);

  tpse_pkg::job_t entry_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_job   = entry_r[rd_ptr_r];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_job;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 2'd1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ----- sv/tpse_front.sv -----
// Front end: accepts items, keeps the running checksum and queues jobs.
module tpse_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [tpse_pkg::CMD_W-1:0]    in_cmd,
  input  logic [tpse_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                          q_full,
  output logic                          q_wr_en,
  output tpse_pkg::job_t                q_job
);

  logic [tpse_pkg::BYTE_W-1:0] checksum_r;
  logic [tpse_pkg::BYTE_W-1:0] checksum_nxt;
  logic                        accept;

  assign full    = q_full;
  assign accept  = push && !q_full;
  assign q_wr_en = accept;

  // The end command sends the checksum in place of the input byte.
  always_comb begin
    q_job.cmd       = in_cmd;
    q_job.data_byte = (in_cmd == tpse_pkg::CMD_END) ? checksum_r : in_data_byte;
  end

  // Data bytes fold into the checksum; the end command clears it.
  always_comb begin
    checksum_nxt = checksum_r;
    if (accept) begin
      case (in_cmd)
        tpse_pkg::CMD_DATA: checksum_nxt = checksum_r ^ in_data_byte;
        tpse_pkg::CMD_END:  checksum_nxt = '0;
        default:            checksum_nxt = checksum_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      checksum_r <= '0;
    end else begin
      checksum_r <= checksum_nxt;
    end
  end

endmodule

// ----- sv/tpse_back.sv -----
// Back end: steps through each job and emits one symbol run per cycle while the result register is free or popped.
module tpse_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  tpse_pkg::job_t    job,
  input  tpse_pkg::cfg_t    cfg,
  output logic              job_pop,
  input  logic              pop,
  output logic              out_valid,
  output tpse_pkg::result_t result
);

  logic [tpse_pkg::STEP_W-1:0] step_r;
  logic [tpse_pkg::STEP_W-1:0] step_nxt;
  logic [tpse_pkg::STEP_W-1:0] step_m1;
  logic [tpse_pkg::STEP_W-1:0] last_step;
  logic                        out_valid_r;
  tpse_pkg::result_t           result_r;
  tpse_pkg::result_t           result_nxt;
  logic                        advance;
  logic                        is_last;
  logic                        bit_val;

  assign out_valid = out_valid_r;
  assign result    = result_r;

  // A new result may enter when the output register is free or being taken.
  assign advance = job_valid && (!out_valid_r || pop);

  // Final step of each job type.
  always_comb begin
    case (job.cmd)
      tpse_pkg::CMD_LEADER: last_step = tpse_pkg::STEP_NEW;
      tpse_pkg::CMD_END:    last_step = tpse_pkg::STEP_GAP;
      default:              last_step = tpse_pkg::STEP_PARITY;
    endcase
  end

  assign is_last  = (step_r == last_step);
  assign job_pop  = advance && is_last;
  assign step_nxt = is_last ? tpse_pkg::STEP_NEW : step_r + 4'd1;

  // Data bits go LSB first; the parity step sends odd parity.
  assign step_m1 = step_r - 4'd1;
  assign bit_val = (step_r == tpse_pkg::STEP_PARITY) ? ~^job.data_byte
                                                     : job.data_byte[step_m1[2:0]];

  // Symbol for the current step.
  always_comb begin
    result_nxt.last         = is_last;
    result_nxt.repeat_count = tpse_pkg::REPEAT_ONE;
    if (job.cmd == tpse_pkg::CMD_LEADER) begin
      result_nxt.symbol_kind    = tpse_pkg::KIND_SYNC;
      result_nxt.first_half_us  = cfg.short_half_us;
      result_nxt.second_half_us = cfg.short_half_us;
      result_nxt.repeat_count   = cfg.leader_sync_symbols;
    end else begin
      case (step_r)
        tpse_pkg::STEP_NEW: begin
          result_nxt.symbol_kind    = tpse_pkg::KIND_NEW;
          result_nxt.first_half_us  = cfg.long_half_us;
          result_nxt.second_half_us = cfg.medium_half_us;
        end
        tpse_pkg::STEP_MARK: begin
          result_nxt.symbol_kind    = tpse_pkg::KIND_END;
          result_nxt.first_half_us  = cfg.long_half_us;
          result_nxt.second_half_us = cfg.short_half_us;
        end
        tpse_pkg::STEP_GAP: begin
          result_nxt.symbol_kind    = tpse_pkg::KIND_SYNC;
          result_nxt.first_half_us  = cfg.short_half_us;
          result_nxt.second_half_us = cfg.short_half_us;
          result_nxt.repeat_count   = cfg.gap_sync_symbols;
        end
        default: begin
          if (bit_val) begin
            result_nxt.symbol_kind    = tpse_pkg::KIND_ONE;
            result_nxt.first_half_us  = cfg.medium_half_us;
            result_nxt.second_half_us = cfg.short_half_us;
          end else begin
            result_nxt.symbol_kind    = tpse_pkg::KIND_ZERO;
            result_nxt.first_half_us  = cfg.short_half_us;
            result_nxt.second_half_us = cfg.medium_half_us;
          end
        end
      endcase
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  // Step counter and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= tpse_pkg::STEP_NEW;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        step_r      <= step_nxt;
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/tape_pulse_symbol_encoder.sv -----
// Top level of the tape pulse symbol encoder.
//
//  Channel   Handshake        Payload
//  input     push / full      in_cmd, in_data_byte
//  result    empty / pop      out_symbol_kind, out_first_half_us, out_second_half_us,
//                             out_repeat_count, out_last
//  config    cfg_wr_en        cfg_index, cfg_data
//
// The back end emits one result per cycle while a job is queued and the result register
// is free or popped: a leader item gives 1 result, a byte item 10 and an end item 12, all
// through the single result register of the step sequencer. A two-entry job queue lets
// the front accept items while the back is busy. Reset is synchronous and active low and
// restores the register defaults and a zero checksum. A stalled result holds on the ports until it is popped.
`include "tape_pulse_symbol_encoder_defines.svh"

module tape_pulse_symbol_encoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [tpse_pkg::CMD_W-1:0]         in_cmd,
  input  logic [tpse_pkg::BYTE_W-1:0]        in_data_byte,
  output logic                               empty,
  input  logic                               pop,
  output logic [tpse_pkg::KIND_W-1:0]        out_symbol_kind,
  output logic [tpse_pkg::US_W-1:0]          out_first_half_us,
  output logic [tpse_pkg::US_W-1:0]          out_second_half_us,
  output logic [tpse_pkg::US_W-1:0]          out_repeat_count,
  output logic                               out_last,
  input  logic                               cfg_wr_en,
  input  logic [tpse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpse_pkg::US_W-1:0]          cfg_data
);

  tpse_pkg::cfg_t    cfg_r;
  tpse_pkg::job_t    front_job;
  tpse_pkg::job_t    head_job;
  tpse_pkg::result_t result;
  logic              q_wr_en;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic              out_valid;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_half_us       <= tpse_pkg::RST_SHORT;
      cfg_r.medium_half_us      <= tpse_pkg::RST_MEDIUM;
      cfg_r.long_half_us        <= tpse_pkg::RST_LONG;
      cfg_r.leader_sync_symbols <= tpse_pkg::RST_LEADER;
      cfg_r.gap_sync_symbols    <= tpse_pkg::RST_GAP;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tpse_pkg::REG_SHORT:  cfg_r.short_half_us       <= cfg_data;
        tpse_pkg::REG_MEDIUM: cfg_r.medium_half_us      <= cfg_data;
        tpse_pkg::REG_LONG:   cfg_r.long_half_us        <= cfg_data;
        tpse_pkg::REG_LEADER: cfg_r.leader_sync_symbols <= cfg_data;
        tpse_pkg::REG_GAP:    cfg_r.gap_sync_symbols    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: classification and checksum.
  tpse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_wr_en      (q_wr_en),
    .q_job        (front_job)
  );

  // Job queue between the two halves.
  tpse_job_q u_job_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr_en),
    .wr_job   (front_job),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_job   (head_job)
  );

  // Back end: symbol sequencer and result register.
  tpse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (head_job),
    .cfg       (cfg_r),
    .job_pop   (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .result    (result)
  );

  assign empty              = ~out_valid;
  assign out_symbol_kind    = result.symbol_kind;
  assign out_first_half_us  = result.first_half_us;
  assign out_second_half_us = result.second_half_us;
  assign out_repeat_count   = result.repeat_count;
  assign out_last           = result.last;

  // A job never ends on a new-byte or end marker.
  `TPSE_ASSERT_SAME(a_last_kind, clk, rst_n, !empty && out_last, out_symbol_kind != tpse_pkg::KIND_NEW && out_symbol_kind != tpse_pkg::KIND_END)
  // Only the final result of a job can carry a run longer than one.
  `TPSE_ASSERT_SAME(a_inner_repeat, clk, rst_n, !empty && !out_last, out_repeat_count == tpse_pkg::REPEAT_ONE)
  // Taking a result that is not the last of its job leaves the next one ready.
  `TPSE_ASSERT_NEXT(a_job_continues, clk, rst_n, pop && !empty && !out_last, !empty)

endmodule
